>>> rtl/hmu_pkg.sv
package hmu_pkg;

   // network size
   localparam int NUM_NEURONS  = 64;
   localparam int NUM_PATTERNS = 2;

   // field widths
   localparam int OP_W     = 2;
   localparam int IDX_W    = 6;
   localparam int SEL_W    = 1;
   localparam int SAMPLE_W = 16;
   localparam int TEMP_W   = 16;
   localparam int ENERGY_W = 20;

   localparam logic [TEMP_W-1:0] TEMP_RESET = 16'd13422;

   // stream word layout
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - ENERGY_W - 2;

   // derived sizes
   localparam int J_W        = $clog2(NUM_NEURONS);
   localparam int K_W        = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
   localparam int PAT_DEPTH  = NUM_NEURONS * NUM_PATTERNS;
   localparam int PA_W       = $clog2(PAT_DEPTH);
   localparam int CNT_W      = $clog2(NUM_NEURONS + 1);
   localparam int CV_W       = CNT_W + 1;
   localparam int PROD_W     = 2 * CV_W;
   localparam int STEP_W     = $clog2(NUM_PATTERNS + 1);
   localparam int RHS_W      = TEMP_W + SAMPLE_W;
   localparam int FRAC_SHIFT = 16;
   localparam int LHS_W      = ENERGY_W - 1 + FRAC_SHIFT;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_PATTERN = 2'd0,
      OP_LOAD_SPIN    = 2'd1,
      OP_STEP         = 2'd2,
      OP_NOP          = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_CENTER,
      ST_SUM,
      ST_DRAIN,
      ST_DECIDE,
      ST_DONE
   } state_type;

   typedef logic [NUM_PATTERNS-1:0][CNT_W-1:0] count_array_type;

   typedef struct packed {
      logic [PA_W-1:0] pat_rd_addr;
      logic [J_W-1:0]  spin_rd_addr;
      logic            pat_we;
      logic [PA_W-1:0] pat_wr_addr;
      logic            pat_wr_bit;
      logic            spin_we;
      logic [J_W-1:0]  spin_wr_addr;
      logic            spin_wr_bit;
      logic            cnt_inc;
      logic            cnt_dec;
      logic [K_W-1:0]  cnt_sel;
   } store_cmd_type;

   typedef struct packed {
      logic pat_bit;
      logic spin_bit;
   } store_rd_type;

   typedef struct packed {
      logic                   clear;
      logic                   valid;
      logic                   pat_bit;
      logic                   spin_bit;
      logic signed [CV_W-1:0] ci;
      logic [CNT_W-1:0]       count;
   } mac_cmd_type;

   typedef struct packed {
      logic                       spin_value;
      logic                       flipped;
      logic signed [ENERGY_W-1:0] energy;
   } result_type;

   // centered pattern value: N*x - ones count
   function automatic logic signed [CV_W-1:0] center_value(input logic bit_in,
                                                          input logic [CNT_W-1:0] count);
      logic signed [CV_W-1:0] n_val;
      logic signed [CV_W-1:0] c_val;
      n_val = bit_in ? CV_W'(NUM_NEURONS) : '0;
      c_val = $signed({1'b0, count});
      return n_val - c_val;
   endfunction

endpackage

>>> rtl/hopfield_metropolis_update_top.sv
// channel  dir  handshake            payload
// req      in   req_tvalid/tready    tdata: neuron_index, pattern_select, bit_value,
//                                    exp_sample; tuser: opcode
// rsp      out  rsp_tvalid/tready    tdata: spin_value, flipped, energy_scaled
// csr      in   csr_wr_en            csr_wr_data: temperature_scaled
//
// loads and no-ops pass through fetch, exec and done from accept to result; a step
// also passes through center, sum, drain and decide, its length set by the shared
// multiply-accumulate unit that takes one neuron/pattern term per cycle.
// reset clears control state, counts and written-entry flags at once; no sweep.
// one item at a time; req_tready is low while an item is in work, and a result
// waiting in the output register holds back only the next result, not the accept.
module hopfield_metropolis_update_top import hmu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [5:0] neuron_index, [6] pattern_select, [7] bit_value, [23:8] exp_sample
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] spin_value, [1] flipped, [21:2] energy_scaled, [23:22] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [TEMP_W-1:0]     csr_wr_data
);

   logic [TEMP_W-1:0]          temperature_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                       start;
   logic                       idle;
   logic                       done;
   logic                       out_busy;
   result_type                 result;
   store_cmd_type              store_cmd;
   store_rd_type               store_rd;
   count_array_type            ones_count;
   mac_cmd_type                mac_cmd;
   logic signed [ENERGY_W-1:0] acc;

   // temperature register
   always_ff @(posedge clock) begin
      if (reset) begin
         temperature_ff <= TEMP_RESET;
      end else if (csr_wr_en) begin
         temperature_ff <= csr_wr_data;
      end
   end

   assign req_tready = idle;
   assign start      = req_tvalid & idle;
   assign out_busy   = rsp_valid_ff & ~rsp_tready;

   hmu_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .op          (req_tuser),
      .idx         (req_tdata[IDX_W-1:0]),
      .sel         (req_tdata[IDX_W +: SEL_W]),
      .bit_value   (req_tdata[IDX_W + SEL_W]),
      .sample      (req_tdata[IDX_W + SEL_W + 1 +: SAMPLE_W]),
      .temperature (temperature_ff),
      .out_busy    (out_busy),
      .idle        (idle),
      .done        (done),
      .result      (result),
      .store_cmd   (store_cmd),
      .store_rd    (store_rd),
      .ones_count  (ones_count),
      .mac_cmd     (mac_cmd),
      .acc         (acc)
   );

   hmu_store u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (store_cmd),
      .rd         (store_rd),
      .ones_count (ones_count)
   );

   hmu_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .acc   (acc)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, result.energy, result.flipped, result.spin_value};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // an accepted word keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted twice in a row");

   // a negative energy change always flips
   a_negative_flips: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[ENERGY_W + 1]) |-> rsp_tdata[1])
      else $error("negative energy change without flip");

   // a result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result overwritten in output register");
`endif

endmodule

>>> rtl/hmu_store.sv
module hmu_store import hmu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  store_cmd_type   cmd,
   output store_rd_type    rd,
   output count_array_type ones_count
);

   logic pat_mem  [PAT_DEPTH];
   logic spin_mem [NUM_NEURONS];

   logic [PAT_DEPTH-1:0]   pat_vld_ff;
   logic [NUM_NEURONS-1:0] spin_vld_ff;
   logic                   pat_data_ff;
   logic                   spin_data_ff;
   logic                   pat_hit_ff;
   logic                   spin_hit_ff;
   count_array_type        count_ff;
   count_array_type        count_in;

   // memory arrays, registered read
   always_ff @(posedge clock) begin
      if (cmd.pat_we) begin
         pat_mem[cmd.pat_wr_addr] <= cmd.pat_wr_bit;
      end
      if (cmd.spin_we) begin
         spin_mem[cmd.spin_wr_addr] <= cmd.spin_wr_bit;
      end
      pat_data_ff  <= pat_mem[cmd.pat_rd_addr];
      spin_data_ff <= spin_mem[cmd.spin_rd_addr];
   end

   // written-entry flags, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_vld_ff  <= '0;
         spin_vld_ff <= '0;
         pat_hit_ff  <= 1'b0;
         spin_hit_ff <= 1'b0;
      end else begin
         if (cmd.pat_we) begin
            pat_vld_ff[cmd.pat_wr_addr] <= 1'b1;
         end
         if (cmd.spin_we) begin
            spin_vld_ff[cmd.spin_wr_addr] <= 1'b1;
         end
         pat_hit_ff  <= pat_vld_ff[cmd.pat_rd_addr];
         spin_hit_ff <= spin_vld_ff[cmd.spin_rd_addr];
      end
   end

   assign rd.pat_bit  = pat_data_ff & pat_hit_ff;
   assign rd.spin_bit = spin_data_ff & spin_hit_ff;

   // per-pattern ones counts
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in[cmd.cnt_sel] = count_ff[cmd.cnt_sel] + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in[cmd.cnt_sel] = count_ff[cmd.cnt_sel] - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign ones_count = count_ff;

endmodule

>>> rtl/hmu_mac.sv
module hmu_mac import hmu_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  mac_cmd_type                cmd,
   output logic signed [ENERGY_W-1:0] acc
);

   logic signed [CV_W-1:0]     cj;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       neg_ff;
   logic                       pvld_ff;
   logic signed [ENERGY_W-1:0] acc_in;
   logic signed [ENERGY_W-1:0] acc_ff;

   // stage 1: centered product
   assign cj      = center_value(cmd.pat_bit, cmd.count);
   assign prod_in = cmd.ci * cj;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= cmd.spin_bit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= cmd.valid;
      end
   end

   // stage 2: signed accumulate, subtract where the spin is one
   always_comb begin
      acc_in = acc_ff;
      if (cmd.clear) begin
         acc_in = '0;
      end else if (pvld_ff) begin
         if (neg_ff) begin
            acc_in = acc_ff - ENERGY_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ENERGY_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> rtl/hmu_seq.sv
module hmu_seq import hmu_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [OP_W-1:0]            op,
   input  logic [IDX_W-1:0]           idx,
   input  logic [SEL_W-1:0]           sel,
   input  logic                       bit_value,
   input  logic [SAMPLE_W-1:0]        sample,
   input  logic [TEMP_W-1:0]          temperature,
   input  logic                       out_busy,
   output logic                       idle,
   output logic                       done,
   output result_type                 result,
   output store_cmd_type              store_cmd,
   input  store_rd_type               store_rd,
   input  count_array_type            ones_count,
   output mac_cmd_type                mac_cmd,
   input  logic signed [ENERGY_W-1:0] acc
);

   state_type              state_ff, state_in;
   opcode_type             op_ff, op_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SEL_W-1:0]       sel_ff, sel_in;
   logic                   bit_ff, bit_in;
   logic [RHS_W-1:0]       rhs_ff, rhs_in;
   logic                   si_ff, si_in;
   logic [J_W-1:0]         j_ff, j_in;
   logic [K_W-1:0]         k_ff, k_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic signed [CV_W-1:0] ci_ff [NUM_PATTERNS];
   logic signed [CV_W-1:0] ci_in [NUM_PATTERNS];
   logic                   tag_vld_ff, tag_vld_in;
   logic [K_W-1:0]         tag_k_ff, tag_k_in;
   logic                   tag_self_ff, tag_self_in;
   result_type             res_ff, res_in;

   logic                       idx_ok;
   logic                       sel_ok;
   logic [J_W-1:0]             idx_j;
   logic signed [ENERGY_W-1:0] d_val;
   logic [LHS_W-1:0]           lhs;
   logic                       flip;

   function automatic logic [PA_W-1:0] pat_addr(input logic [K_W-1:0] k,
                                               input logic [J_W-1:0] j);
      return PA_W'(PA_W'(k) * PA_W'(NUM_NEURONS)) + PA_W'(j);
   endfunction

   assign idx_ok = (int'(idx_ff) < NUM_NEURONS);
   assign sel_ok = (int'(sel_ff) < NUM_PATTERNS);
   assign idx_j  = J_W'(idx_ff);
   assign idle   = (state_ff == ST_IDLE);
   assign result = res_ff;

   // Metropolis decision on the finished sum
   always_comb begin
      d_val = si_ff ? -acc : acc;
      lhs   = {d_val[ENERGY_W-2:0], {FRAC_SHIFT{1'b0}}};
      flip  = d_val[ENERGY_W-1] || (d_val == '0) || (lhs < LHS_W'(rhs_ff));
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      idx_in      = idx_ff;
      sel_in      = sel_ff;
      bit_in      = bit_ff;
      rhs_in      = rhs_ff;
      si_in       = si_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      step_in     = step_ff;
      ci_in       = ci_ff;
      res_in      = res_ff;
      tag_vld_in  = 1'b0;
      tag_k_in    = k_ff;
      tag_self_in = 1'b0;
      done        = 1'b0;

      store_cmd              = '0;
      store_cmd.pat_rd_addr  = pat_addr(k_ff, j_ff);
      store_cmd.spin_rd_addr = j_ff;

      mac_cmd          = '0;
      mac_cmd.valid    = tag_vld_ff & ~tag_self_ff;
      mac_cmd.pat_bit  = store_rd.pat_bit;
      mac_cmd.spin_bit = store_rd.spin_bit;
      mac_cmd.ci       = ci_ff[tag_k_ff];
      mac_cmd.count    = ones_count[tag_k_ff];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = opcode_type'(op);
               idx_in   = idx;
               sel_in   = sel;
               bit_in   = bit_value;
               rhs_in   = RHS_W'(temperature) * RHS_W'(sample);
               state_in = ST_FETCH;
            end
         end

         // read the addressed spin and pattern bit
         ST_FETCH: begin
            store_cmd.pat_rd_addr  = pat_addr(K_W'(sel_ff), idx_j);
            store_cmd.spin_rd_addr = idx_j;
            state_in               = ST_EXEC;
         end

         ST_EXEC: begin
            si_in    = store_rd.spin_bit;
            res_in   = '{spin_value: store_rd.spin_bit, flipped: 1'b0, energy: '0};
            state_in = ST_DONE;
            if (!idx_ok) begin
               res_in = '0;
            end else begin
               unique case (op_ff)
                  OP_LOAD_PATTERN: begin
                     if (sel_ok && (store_rd.pat_bit != bit_ff)) begin
                        store_cmd.pat_we      = 1'b1;
                        store_cmd.pat_wr_addr = pat_addr(K_W'(sel_ff), idx_j);
                        store_cmd.pat_wr_bit  = bit_ff;
                        store_cmd.cnt_inc     = bit_ff;
                        store_cmd.cnt_dec     = ~bit_ff;
                        store_cmd.cnt_sel     = K_W'(sel_ff);
                     end
                  end
                  OP_LOAD_SPIN: begin
                     store_cmd.spin_we      = 1'b1;
                     store_cmd.spin_wr_addr = idx_j;
                     store_cmd.spin_wr_bit  = bit_ff;
                     res_in.spin_value      = bit_ff;
                  end
                  OP_STEP: begin
                     step_in  = '0;
                     state_in = ST_CENTER;
                  end
                  OP_NOP: begin
                  end
               endcase
            end
         end

         // centered values of the addressed neuron, one pattern a cycle
         ST_CENTER: begin
            mac_cmd.clear         = 1'b1;
            store_cmd.pat_rd_addr = pat_addr(K_W'(step_ff), idx_j);
            if (step_ff != '0) begin
               ci_in[K_W'(step_ff - 1'b1)] =
                  center_value(store_rd.pat_bit, ones_count[K_W'(step_ff - 1'b1)]);
            end
            if (step_ff == STEP_W'(NUM_PATTERNS)) begin
               j_in     = '0;
               k_in     = '0;
               state_in = ST_SUM;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         // sweep every neuron and pattern through the mac, the addressed neuron's own terms masked
         ST_SUM: begin
            tag_vld_in  = 1'b1;
            tag_k_in    = k_ff;
            tag_self_in = (j_ff == idx_j);
            if (k_ff == K_W'(NUM_PATTERNS - 1)) begin
               k_in = '0;
               if (j_ff == J_W'(NUM_NEURONS - 1)) begin
                  step_in  = '0;
                  state_in = ST_DRAIN;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         // let the last terms pass the product and sum stages
         ST_DRAIN: begin
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_DECIDE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         ST_DECIDE: begin
            res_in = '{spin_value: si_ff ^ flip, flipped: flip, energy: d_val};
            if (flip) begin
               store_cmd.spin_we      = 1'b1;
               store_cmd.spin_wr_addr = idx_j;
               store_cmd.spin_wr_bit  = ~si_ff;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!out_busy) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tag_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tag_vld_ff <= tag_vld_in;
      end
   end

   // item and working registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      sel_ff      <= sel_in;
      bit_ff      <= bit_in;
      rhs_ff      <= rhs_in;
      si_ff       <= si_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      step_ff     <= step_in;
      ci_ff       <= ci_in;
      tag_k_ff    <= tag_k_in;
      tag_self_ff <= tag_self_in;
      res_ff      <= res_in;
   end

endmodule
